/* hdl/abe_pkg.sv */
// ----------------------------------------------------------------------------
// abe_pkg
// Shared widths, constants and the controller state type of the
// acknowledged bitrate estimator.
// ----------------------------------------------------------------------------
package abe_pkg;

    // field and datapath widths
    localparam int TS_W    = 40;            // timestamp width in ms
    localparam int SIG_W   = TS_W + 1;      // signed timestamp width
    localparam int FB      = 16;            // fraction bits
    localparam int EST_W   = 40;            // estimate and variance width
    localparam int UNC_W   = 32;            // uncertainty and byte sum width
    localparam int WIN_W   = 12;            // window register width
    localparam int ELP_W   = 16;            // elapsed time width
    localparam int SIZE_W  = 16;            // payload size width
    localparam int CFG_W   = 16;            // config data width
    localparam int IDX_W   = 2;             // config index width
    localparam int DIV_W   = 2 * EST_W + 1; // serial divider dividend width
    localparam int DEN_W   = EST_W + 1;     // serial divider divisor width
    localparam int MUL_W   = EST_W;         // serial multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;     // serial multiplier product width
    localparam int CNT_W   = 7;             // step counter width
    localparam int IN_W    = 144;           // input tdata width
    localparam int OUT_W   = 32;            // output tdata width

    // step counts of the serial units
    localparam logic [CNT_W-1:0] STEPS_MOD = CNT_W'(SIG_W);
    localparam logic [CNT_W-1:0] STEPS_SMP = CNT_W'(UNC_W + 3 + FB);
    localparam logic [CNT_W-1:0] STEPS_UNC = CNT_W'(EST_W + 4 + FB);
    localparam logic [CNT_W-1:0] STEPS_MRG = CNT_W'(DIV_W);
    localparam logic [CNT_W-1:0] STEPS_MUL = CNT_W'(MUL_W);

    // reset values
    localparam logic [WIN_W-1:0]  RATE_WIN_RST  = 12'd150;
    localparam logic [WIN_W-1:0]  INIT_WIN_RST  = 12'd500;
    localparam logic [CFG_W-1:0]  BOOST_RST     = 16'd200;
    localparam logic [CFG_W-1:0]  NOISE_RST     = 16'd5;
    localparam logic [EST_W-1:0]  VAR_RST       = EST_W'(50) << FB;
    localparam logic [EST_W-1:0]  WIDE_MAX      = '1;
    localparam logic [UNC_W-1:0]  UNC_MAX       = '1;

    // config register indexes
    localparam logic [IDX_W-1:0] REG_RATE_WIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_INIT_WIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOOST    = 2'd2;
    localparam logic [IDX_W-1:0] REG_NOISE    = 2'd3;

    // item kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN,
        S_MOD,
        S_CHK,
        S_SMP,
        S_MRG,
        S_UDIV,
        S_USQ,
        S_MUL1,
        S_MUL2,
        S_DIV1,
        S_MUL3,
        S_DIV2,
        S_OUT
    } t_state;

endpackage

/* hdl/acked_bitrate_estimator.sv */
// ----------------------------------------------------------------------------
// acked_bitrate_estimator
// Windowed byte counting of acknowledged packets with an inverse-variance
// filtered rate estimate, built around a bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries feedback items: tuser is the kind (packet or notice),
//   tdata the send time, arrival time, payload size and notice time.
//   m_axis returns one item per input item: tdata the rate in bps,
//   tuser the has-estimate flag. The cfg channel writes the four registers
//   by index and is always ready; write it only while the block is idle.
// Operation
//   One item is worked on at a time. A notice or a skipped packet goes
//   straight to the output; a packet updates the window, with a modulo
//   when a long gap needs it. A closed window adds the sample division, and
//   a merge more: the restoring divider retires one quotient bit per cycle
//   and the shift-add multiplier one multiplier bit.
// Reset and stall
//   Reset restores the register defaults and clears the estimate. A new
//   item is taken while the previous result still waits in the output
//   register; a stalled receiver holds the block once its next result is
//   ready.
// ----------------------------------------------------------------------------
module acked_bitrate_estimator
    import abe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // send time[40:0], arrival time[80:41], payload bytes[96:81],
    // notice time[137:97]
    input  logic [IN_W-1:0]   s_axis_tdata,
    // kind
    input  logic              s_axis_tuser,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // bitrate_bps[31:0]
    output logic [OUT_W-1:0]  m_axis_tdata,
    // has_estimate
    output logic              m_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [WIN_W-1:0] r_rate_win, n_rate_win;
    logic [WIN_W-1:0] r_init_win, n_init_win;
    logic [CFG_W-1:0] r_boost, n_boost;
    logic [CFG_W-1:0] r_noise, n_noise;

    // architectural state
    logic [SIG_W-1:0] r_alr_end, n_alr_end;
    logic             r_prev_ok, n_prev_ok;
    logic [TS_W-1:0]  r_prev, n_prev;
    logic [ELP_W-1:0] r_elapsed, n_elapsed;
    logic [UNC_W-1:0] r_bytes, n_bytes;
    logic [EST_W-1:0] r_est, n_est;
    logic             r_est_ok, n_est_ok;
    logic [EST_W-1:0] r_var, n_var;

    // output register
    logic             r_out_vld, n_out_vld;
    logic [OUT_W-1:0] r_out_bps, n_out_bps;
    logic             r_out_est, n_out_est;

    // item and merge working registers
    logic [TS_W-1:0]   r_now, n_now;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [WIN_W-1:0]  r_wnd, n_wnd;
    logic [EST_W-1:0]  r_smp, n_smp;
    logic [EST_W-1:0]  r_sv, n_sv;
    logic [EST_W-1:0]  r_p, n_p;
    logic [DEN_W-1:0]  r_tot, n_tot;
    logic [PROD_W-1:0] r_acc, n_acc;

    // serial units
    logic [DIV_W-1:0]  r_dq, n_dq;
    logic [DEN_W-1:0]  r_dr, n_dr;
    logic [DEN_W-1:0]  r_dd, n_dd;
    logic [PROD_W-1:0] r_mp, n_mp;
    logic [MUL_W-1:0]  r_mm, n_mm;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // combinational helpers
    logic              w_in_acc;
    logic [WIN_W-1:0]  w_wsel, w_wnd;
    logic [SIG_W-1:0]  w_send, w_alr_in;
    logic [DEN_W-1:0]  w_boost_sum;
    logic [TS_W-1:0]   w_delta;
    logic [SIG_W-1:0]  w_c;
    logic [DEN_W:0]    w_rr;
    logic              w_ge;
    logic [DEN_W:0]    w_rsub;
    logic [MUL_W:0]    w_madd;
    logic [EST_W-1:0]  w_q40;
    logic [UNC_W-1:0]  w_q32;
    logic [EST_W-1:0]  w_d;
    logic [EST_W+3:0]  w_tend;
    logic [EST_W-1:0]  w_sv;
    logic [DEN_W-1:0]  w_psum;
    logic [EST_W-1:0]  w_p;
    logic [DEN_W-1:0]  w_tot;
    logic [DIV_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_mean;
    logic [UNC_W:0]    w_bsum;
    logic [UNC_W-1:0]  w_bytes_sat;
    logic [EST_W+9:0]  w_k;
    logic [OUT_W-1:0]  w_bps;

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_bps;
    assign m_axis_tuser  = r_out_est;

    // field extraction and window length
    assign w_send   = s_axis_tdata[SIG_W-1:0];
    assign w_alr_in = s_axis_tdata[2*TS_W+SIZE_W+SIG_W:2*TS_W+SIZE_W+1];
    assign w_wsel   = r_est_ok ? r_rate_win : r_init_win;
    assign w_wnd    = (w_wsel == '0) ? WIN_W'(1) : w_wsel;
    assign w_boost_sum = {1'b0, r_var}
                       + {{(DEN_W-CFG_W-FB){1'b0}}, r_boost, {FB{1'b0}}};

    // window bookkeeping
    assign w_delta = r_now - r_prev;
    assign w_c     = {{(SIG_W-ELP_W){1'b0}}, r_elapsed} + {1'b0, w_delta};
    assign w_bsum  = {1'b0, r_bytes} + {{(UNC_W-SIZE_W+1){1'b0}}, r_size};
    assign w_bytes_sat = w_bsum[UNC_W] ? UNC_MAX : w_bsum[UNC_W-1:0];

    // divider step: one quotient bit per cycle
    assign w_rr   = {r_dr, r_dq[DIV_W-1]};
    assign w_ge   = (w_rr >= {1'b0, r_dd});
    assign w_rsub = w_rr - {1'b0, r_dd};
    assign w_q40  = (|r_dq[DIV_W-1:EST_W]) ? WIDE_MAX : r_dq[EST_W-1:0];
    assign w_q32  = (|r_dq[DIV_W-1:UNC_W]) ? UNC_MAX : r_dq[UNC_W-1:0];

    // multiplier step: one multiplier bit per cycle
    assign w_madd = {1'b0, r_mp[PROD_W-1:MUL_W]}
                  + (r_mp[0] ? {1'b0, r_mm} : {(MUL_W+1){1'b0}});

    // merge terms
    assign w_d    = (r_est > r_smp) ? (r_est - r_smp) : (r_smp - r_est);
    assign w_tend = {1'b0, w_d, 3'b000} + {3'b000, w_d, 1'b0};
    assign w_sv   = (|r_mp[PROD_W-1:EST_W+FB]) ? WIDE_MAX : r_mp[EST_W+FB-1:FB];
    assign w_psum = {1'b0, r_var}
                  + {{(DEN_W-CFG_W-FB){1'b0}}, r_noise, {FB{1'b0}}};
    assign w_p    = w_psum[EST_W] ? WIDE_MAX : w_psum[EST_W-1:0];
    assign w_tot  = {1'b0, r_sv} + {1'b0, r_p};
    assign w_num  = {1'b0, r_acc} + {1'b0, r_mp};
    assign w_mean = {1'b0, r_est} + {1'b0, r_smp};

    // rate in bps: est * 1000 >> FB, 1000 = 1024 - 16 - 8
    assign w_k   = {r_est, 10'b0} - {6'b0, r_est, 4'b0} - {7'b0, r_est, 3'b0};
    assign w_bps = !r_est_ok ? '0
                 : (|w_k[EST_W+9:OUT_W+FB]) ? UNC_MAX : w_k[OUT_W+FB-1:FB];

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_rate_win = r_rate_win;
        n_init_win = r_init_win;
        n_boost    = r_boost;
        n_noise    = r_noise;
        n_alr_end  = r_alr_end;
        n_prev_ok  = r_prev_ok;
        n_prev     = r_prev;
        n_elapsed  = r_elapsed;
        n_bytes    = r_bytes;
        n_est      = r_est;
        n_est_ok   = r_est_ok;
        n_var      = r_var;
        n_out_vld  = r_out_vld;
        n_out_bps  = r_out_bps;
        n_out_est  = r_out_est;
        n_now      = r_now;
        n_size     = r_size;
        n_wnd      = r_wnd;
        n_smp      = r_smp;
        n_sv       = r_sv;
        n_p        = r_p;
        n_tot      = r_tot;
        n_acc      = r_acc;
        n_dq       = r_dq;
        n_dr       = r_dr;
        n_dd       = r_dd;
        n_mp       = r_mp;
        n_mm       = r_mm;
        n_cnt      = r_cnt;

        // register writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATE_WIN: n_rate_win = i_cfg_data[WIN_W-1:0];
                REG_INIT_WIN: n_init_win = i_cfg_data[WIN_W-1:0];
                REG_BOOST:    n_boost    = i_cfg_data;
                REG_NOISE:    n_noise    = i_cfg_data;
                default:      n_boost    = r_boost;
            endcase
        end

        // result taken by the receiver
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        // serial units step while their count runs
        if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_dr  = w_ge ? w_rsub[DEN_W-1:0] : w_rr[DEN_W-1:0];
            n_dq  = {r_dq[DIV_W-2:0], w_ge};
            n_mp  = {w_madd, r_mp[MUL_W-1:1]};
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_now  = s_axis_tdata[2*TS_W:SIG_W];
                    n_size = s_axis_tdata[2*TS_W+SIZE_W:2*TS_W+1];
                    n_wnd  = w_wnd;
                    n_state = S_OUT;
                    if (s_axis_tuser == KIND_NOTICE) begin
                        n_alr_end = w_alr_in;
                    end else if (!w_send[SIG_W-1]) begin
                        // first later-sent packet after a notice
                        if (!r_alr_end[SIG_W-1] && ($signed(w_send) > $signed(r_alr_end)))
                        begin
                            n_var     = w_boost_sum[EST_W] ? WIDE_MAX
                                                           : w_boost_sum[EST_W-1:0];
                            n_alr_end = '1;
                        end
                        n_state = S_WIN;
                    end
                end
            end
            S_WIN: begin
                n_prev    = r_now;
                n_prev_ok = 1'b1;
                n_state   = S_CHK;
                if (r_prev_ok && (r_now < r_prev)) begin
                    // time went backwards: restart empty
                    n_bytes   = '0;
                    n_elapsed = '0;
                end else if (r_prev_ok) begin
                    if (w_delta > {{(TS_W-WIN_W){1'b0}}, r_wnd}) begin
                        // long gap: drop bytes, elapsed modulo window
                        n_bytes = '0;
                        n_dq    = {w_c, {(DIV_W-SIG_W){1'b0}}};
                        n_dr    = '0;
                        n_dd    = {{(DEN_W-WIN_W){1'b0}}, r_wnd};
                        n_cnt   = STEPS_MOD;
                        n_state = S_MOD;
                    end else begin
                        n_elapsed = w_c[ELP_W-1:0];
                    end
                end
            end
            S_MOD: begin
                if (r_cnt == '0) begin
                    n_elapsed = r_dr[ELP_W-1:0];
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (r_elapsed >= {{(ELP_W-WIN_W){1'b0}}, r_wnd}) begin
                    // window full: sample = bytes * 8 / window
                    n_dq      = {r_bytes, {(DIV_W-UNC_W){1'b0}}};
                    n_dr      = '0;
                    n_dd      = {{(DEN_W-WIN_W){1'b0}}, r_wnd};
                    n_cnt     = STEPS_SMP;
                    n_elapsed = r_elapsed - {{(ELP_W-WIN_W){1'b0}}, r_wnd};
                    n_bytes   = {{(UNC_W-SIZE_W){1'b0}}, r_size};
                    n_state   = S_SMP;
                end else begin
                    n_bytes = w_bytes_sat;
                    n_state = S_OUT;
                end
            end
            S_SMP: begin
                if (r_cnt == '0) begin
                    n_smp   = w_q40;
                    n_state = S_MRG;
                    if (!r_est_ok) begin
                        n_est    = w_q40;
                        n_est_ok = 1'b1;
                        n_state  = S_OUT;
                    end
                end
            end
            S_MRG: begin
                if (r_est == '0) begin
                    // uncertainty saturates
                    n_mp    = {{MUL_W{1'b0}}, {(MUL_W-UNC_W){1'b0}}, UNC_MAX};
                    n_mm    = {{(MUL_W-UNC_W){1'b0}}, UNC_MAX};
                    n_cnt   = STEPS_MUL;
                    n_state = S_USQ;
                end else begin
                    n_dq    = {w_tend, {(DIV_W-EST_W-4){1'b0}}};
                    n_dr    = '0;
                    n_dd    = {1'b0, r_est};
                    n_cnt   = STEPS_UNC;
                    n_state = S_UDIV;
                end
            end
            S_UDIV: begin
                if (r_cnt == '0) begin
                    n_mp    = {{MUL_W{1'b0}}, {(MUL_W-UNC_W){1'b0}}, w_q32};
                    n_mm    = {{(MUL_W-UNC_W){1'b0}}, w_q32};
                    n_cnt   = STEPS_MUL;
                    n_state = S_USQ;
                end
            end
            S_USQ: begin
                if (r_cnt == '0) begin
                    n_sv    = w_sv;
                    n_p     = w_p;
                    n_mp    = {{MUL_W{1'b0}}, r_est};
                    n_mm    = w_sv;
                    n_cnt   = STEPS_MUL;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                if (r_cnt == '0) begin
                    n_acc   = r_mp;
                    n_mp    = {{MUL_W{1'b0}}, r_smp};
                    n_mm    = r_p;
                    n_cnt   = STEPS_MUL;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (r_cnt == '0) begin
                    n_tot = w_tot;
                    if (w_tot == '0) begin
                        // zero total variance: plain mean
                        n_est   = w_mean[DEN_W-1:1];
                        n_var   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_dq    = w_num;
                        n_dr    = '0;
                        n_dd    = w_tot;
                        n_cnt   = STEPS_MRG;
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                if (r_cnt == '0) begin
                    n_est   = w_q40;
                    n_mp    = {{MUL_W{1'b0}}, r_p};
                    n_mm    = r_sv;
                    n_cnt   = STEPS_MUL;
                    n_state = S_MUL3;
                end
            end
            S_MUL3: begin
                if (r_cnt == '0) begin
                    n_dq    = {1'b0, r_mp};
                    n_dr    = '0;
                    n_dd    = r_tot;
                    n_cnt   = STEPS_MRG;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (r_cnt == '0) begin
                    n_var   = w_q40;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out_bps = w_bps;
                    n_out_est = r_est_ok;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rate_win <= RATE_WIN_RST;
            r_init_win <= INIT_WIN_RST;
            r_boost    <= BOOST_RST;
            r_noise    <= NOISE_RST;
            r_alr_end  <= '1;
            r_prev_ok  <= 1'b0;
            r_elapsed  <= '0;
            r_bytes    <= '0;
            r_est      <= '0;
            r_est_ok   <= 1'b0;
            r_var      <= VAR_RST;
            r_out_vld  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_rate_win <= n_rate_win;
            r_init_win <= n_init_win;
            r_boost    <= n_boost;
            r_noise    <= n_noise;
            r_alr_end  <= n_alr_end;
            r_prev_ok  <= n_prev_ok;
            r_elapsed  <= n_elapsed;
            r_bytes    <= n_bytes;
            r_est      <= n_est;
            r_est_ok   <= n_est_ok;
            r_var      <= n_var;
            r_out_vld  <= n_out_vld;
            r_cnt      <= n_cnt;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_prev    <= n_prev;
        r_out_bps <= n_out_bps;
        r_out_est <= n_out_est;
        r_now     <= n_now;
        r_size    <= n_size;
        r_wnd     <= n_wnd;
        r_smp     <= n_smp;
        r_sv      <= n_sv;
        r_p       <= n_p;
        r_tot     <= n_tot;
        r_acc     <= n_acc;
        r_dq      <= n_dq;
        r_dr      <= n_dr;
        r_dd      <= n_dd;
        r_mp      <= n_mp;
        r_mm      <= n_mm;
    end

    // an estimate once made is never lost
    a_est_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_est_ok |=> r_est_ok)
        else $error("estimate flag cleared");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("item accepted without leaving idle");

    // finishing an item loads the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |=> r_out_vld)
        else $error("result lost");

    // no rate without an estimate
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_est) |-> (r_out_bps == '0))
        else $error("nonzero rate without estimate");

    // serial units only run in their working states
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("serial unit running while idle");

endmodule
